@@ rtl/brfl_pkg.sv @@
// shared constants, codes and types of the byte ring fifo line reader
`default_nettype none

package brfl_pkg;

  localparam int unsigned DEPTH    = 256;
  localparam int unsigned MAX_LINE = 64;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH);
  localparam int unsigned LEN_W = $clog2(MAX_LINE + 1);
  localparam int unsigned LIM_W = 7;
  localparam int unsigned CMP_W = (CNT_W > LIM_W) ? CNT_W : LIM_W;

  localparam logic [7:0] NL_BYTE = 8'd10;

  // operation selector
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_LINE  = 2'd2;

  // result status
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_EMPTY  = 2'd2;
  localparam logic [1:0] STAT_NOLINE = 2'd3;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic       we;
    ptr_t       waddr;
    logic [7:0] wdata;
  } mem_wr_t;

endpackage

`default_nettype wire

@@ rtl/byte_ring_fifo_line_reader.sv @@
// byte ring fifo with newline count and line read, top level
// a write or an op failing at accept has its result in the next cycle; a byte read passes the
// store read register, then the output register. line read: the scan reads one stored byte per
// cycle up to the newline, then emits the line one byte per cycle while the output is free; no
// newline in the span gives no line. one item is in work at a time
// reset (rst_ni low, async) empties the fifo and clears the newline count; store contents stay
`default_nettype none

module byte_ring_fifo_line_reader (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // wr_byte[7:0], line_limit[14:8], zero pad
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_byte[7:0], line_count[15:8], fill_level[23:16]
  output logic [2:0]  m_axis_tuser,   // byte_valid[0], status[2:1]
  output logic        m_axis_tlast    // last
);
  import brfl_pkg::*;

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;  // waiting for an item
  localparam logic [1:0] ST_RBYTE = 2'd1;  // store data for a byte read is in flight
  localparam logic [1:0] ST_SCAN  = 2'd2;  // looking for the newline
  localparam logic [1:0] ST_EMIT  = 2'd3;  // sending out the line

  localparam logic [CNT_W-1:0] FULL_LEVEL = CNT_W'(DEPTH - 1);

  // ring pointer step with wrap at the store depth
  function automatic ptr_t adv(input ptr_t p);
    logic [PTR_W:0] t;
    t = {1'b0, p} + 1'b1;
    if (t >= (PTR_W + 1)'(DEPTH)) begin
      return '0;
    end
    return t[PTR_W-1:0];
  endfunction

  // bytes stored between read and write pointers
  function automatic logic [CNT_W-1:0] fill_of(input ptr_t wp, input ptr_t rp);
    logic [PTR_W:0] t;
    if (wp >= rp) begin
      t = {1'b0, wp} - {1'b0, rp};
    end else begin
      t = {1'b0, wp} + (PTR_W + 1)'(DEPTH) - {1'b0, rp};
    end
    return t[CNT_W-1:0];
  endfunction

  logic [1:0]       state_q, state_d;
  ptr_t             wp_q, wp_d;
  ptr_t             rp_q, rp_d;
  ptr_t             addr_q, addr_d;     // store read address
  logic [CNT_W-1:0] nl_q, nl_d;         // stored newline count
  logic [LEN_W-1:0] cnt_q, cnt_d;       // position inside the line
  logic [LEN_W-1:0] span_q, span_d;     // bytes the scan may look at
  logic [LEN_W-1:0] len_q, len_d;       // line length, newline included

  // output register
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             out_bv_q;
  logic             out_last_q;
  logic [1:0]       out_stat_q;
  logic [7:0]       out_lc_q;
  logic [7:0]       out_fl_q;

  logic             out_free;
  logic             s_accept;
  logic             emit;
  logic [7:0]       res_byte;
  logic             res_bv;
  logic             res_last;
  logic [1:0]       res_stat;

  mem_wr_t          mem_wr;
  logic [7:0]       rdata;

  logic [1:0]       in_func;
  logic [7:0]       in_byte;
  logic [LIM_W-1:0] in_limit;
  logic [LIM_W-1:0] lim_sat;
  logic [CMP_W-1:0] span_wide;
  logic [CNT_W-1:0] fill_cur;
  logic [CNT_W-1:0] fill_nxt;

  assign in_func  = s_axis_tuser;
  assign in_byte  = s_axis_tdata[7:0];
  assign in_limit = s_axis_tdata[14:8];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign fill_cur = fill_of(wp_q, rp_q);
  assign fill_nxt = fill_of(wp_d, rp_d);

  // limit saturates at the longest line; span is the smaller of limit and fill
  assign lim_sat   = (in_limit > LIM_W'(MAX_LINE)) ? LIM_W'(MAX_LINE) : in_limit;
  assign span_wide = (CMP_W'(fill_cur) < CMP_W'(lim_sat)) ? CMP_W'(fill_cur) : CMP_W'(lim_sat);

  brfl_store u_store (
    .clk_i   (clk_i),
    .wr_i    (mem_wr),
    .raddr_i (addr_d),
    .rdata_o (rdata)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    wp_d     = wp_q;
    rp_d     = rp_q;
    addr_d   = addr_q;
    nl_d     = nl_q;
    cnt_d    = cnt_q;
    span_d   = span_q;
    len_d    = len_q;
    mem_wr   = '0;
    emit     = 1'b0;
    res_byte = 8'd0;
    res_bv   = 1'b0;
    res_last = 1'b1;
    res_stat = STAT_OK;

    unique case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          case (in_func)
            FUNC_WRITE: begin
              emit = 1'b1;
              if (fill_cur == FULL_LEVEL) begin
                res_stat = STAT_FULL;
              end else begin
                mem_wr.we    = 1'b1;
                mem_wr.waddr = wp_q;
                mem_wr.wdata = in_byte;
                wp_d         = adv(wp_q);
                if (in_byte == NL_BYTE) begin
                  nl_d = nl_q + 1'b1;
                end
              end
            end
            FUNC_READ: begin
              if (fill_cur == '0) begin
                emit     = 1'b1;
                res_stat = STAT_EMPTY;
              end else begin
                addr_d  = rp_q;
                state_d = ST_RBYTE;
              end
            end
            FUNC_LINE: begin
              if (nl_q == '0 || span_wide == '0) begin
                emit     = 1'b1;
                res_stat = STAT_NOLINE;
              end else begin
                addr_d  = rp_q;
                cnt_d   = '0;
                span_d  = span_wide[LEN_W-1:0];
                state_d = ST_SCAN;
              end
            end
            default: begin
              // unused selector: taken and dropped
            end
          endcase
        end
      end

      ST_RBYTE: begin
        if (out_free) begin
          emit     = 1'b1;
          res_byte = rdata;
          res_bv   = 1'b1;
          rp_d     = adv(rp_q);
          if (rdata == NL_BYTE && nl_q != '0) begin
            nl_d = nl_q - 1'b1;
          end
          state_d = ST_IDLE;
        end
      end

      ST_SCAN: begin
        if (rdata == NL_BYTE) begin
          // newline found, rewind to the head and stream the line out
          len_d   = cnt_q + 1'b1;
          cnt_d   = '0;
          addr_d  = rp_q;
          state_d = ST_EMIT;
        end else if (cnt_q + 1'b1 == span_q) begin
          if (out_free) begin
            emit     = 1'b1;
            res_stat = STAT_NOLINE;
            state_d  = ST_IDLE;
          end
        end else begin
          cnt_d  = cnt_q + 1'b1;
          addr_d = adv(addr_q);
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          emit     = 1'b1;
          res_byte = rdata;
          res_bv   = 1'b1;
          res_last = (cnt_q + 1'b1 == len_q);
          rp_d     = adv(rp_q);
          addr_d   = adv(addr_q);
          cnt_d    = cnt_q + 1'b1;
          if (res_last) begin
            if (nl_q != '0) begin
              nl_d = nl_q - 1'b1;
            end
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      addr_q      <= '0;
      nl_q        <= '0;
      cnt_q       <= '0;
      span_q      <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      addr_q  <= addr_d;
      nl_q    <= nl_d;
      cnt_q   <= cnt_d;
      span_q  <= span_d;
      len_q   <= len_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, counts taken after this result's update
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= res_byte;
      out_bv_q   <= res_bv;
      out_last_q <= res_last;
      out_stat_q <= res_stat;
      out_lc_q   <= 8'(nl_d);
      out_fl_q   <= 8'(fill_nxt);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_fl_q, out_lc_q, out_byte_q};
  assign m_axis_tuser  = {out_stat_q, out_bv_q};
  assign m_axis_tlast  = out_last_q;

  // newlines stored never outnumber bytes stored
  a_nl_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nl_q <= fill_cur)
    else $error("newline count above fill level");

  // scan position stays inside the allowed span
  a_scan_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q < span_q))
    else $error("scan ran past its span");

  // emit position stays inside the line
  a_emit_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (cnt_q < len_q))
    else $error("emit ran past the line end");

  // a write gives its result in the next cycle
  a_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && in_func == FUNC_WRITE) |=> (m_axis_tvalid && m_axis_tlast))
    else $error("write item gave no result");

  // a line scan only runs while a newline is stored
  a_scan_has_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_EMIT) |-> (nl_q != '0))
    else $error("line scan with no stored newline");

endmodule

`default_nettype wire

@@ rtl/brfl_store.sv @@
// byte store of the ring fifo: one write port, one registered read port
`default_nettype none

module brfl_store (
  input  logic              clk_i,
  input  brfl_pkg::mem_wr_t wr_i,
  input  brfl_pkg::ptr_t    raddr_i,
  output logic [7:0]        rdata_o
);
  import brfl_pkg::*;

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.waddr] <= wr_i.wdata;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
